FILE: rtl/core/fcrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// fcrt_pkg - shared types for the call/return tracer
// Token and lookup types passed along the cell chain, event codes and the
// per-cell lookup step.
// ============================================================================
package fcrt_pkg;

    // Address stride of a sequential instruction
    localparam logic [31:0] STEP_BYTES = 32'd4;

    // Event codes on the result channel
    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_CALL  = 2'd1,
        EV_RET   = 2'd2,
        EV_UNDER = 2'd3
    } t_event;

    // Item moving along the chain. For a load, a/b carry start/size;
    // for a trace they carry the current and the next pc.
    typedef struct packed {
        logic        func;
        logic [7:0]  idx;
        logic [31:0] a;
        logic [31:0] b;
        logic        is_func;
    } t_token;

    // Running lookup state for one address
    typedef struct packed {
        logic        found;
        logic [31:0] off;
        logic [31:0] start;
    } t_hit;

    // One lookup step result
    typedef struct packed {
        logic take;
        t_hit hit;
    } t_match;

    // Compare one entry against the running lookup for address addr
    function automatic t_match match_step(
        input t_hit        h,
        input logic [31:0] addr,
        input logic [31:0] st,
        input logic [31:0] sz,
        input logic        active
    );
        t_match      r;
        logic [31:0] off;
        off    = addr - st;
        r.take = 1'b0;
        r.hit  = h;
        if (active && !h.found && (st <= addr)) begin
            if (off < sz) begin
                r.take      = 1'b1;
                r.hit.found = 1'b1;
                r.hit.start = st;
            end else if (off < h.off) begin
                r.take      = 1'b1;
                r.hit.off   = off;
                r.hit.start = st;
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/function_call_return_tracer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// function_call_return_tracer_top - function call/return tracer
// A chain of SYMBOLS cells, one table slot each, that loads entries and
// maps both addresses of a trace item to function entries, followed by the
// call/return classifier.
//
//   channel   handshake                    payload
//   -------   --------------------------   --------------------------------
//   input     i_valid / o_stall            i_func, i_entry_*, i_cur_pc, ...
//   result    o_valid / i_stall            o_event_res, o_from_*, o_to_* ...
//   config    i_cfg_valid / o_cfg_ready    i_cfg_symbol_count
//
// One item enters per cycle while the result channel is not stalled; each
// passes through the register of every cell and then the result register.
// Loads and lookups travel in order, so an item sees every earlier load.
// Reset clears the valid bits and the call depth; table slots are undefined
// until loaded. A stalled result freezes the whole chain and the input.
// ============================================================================
module function_call_return_tracer_top #(
    parameter int SYMBOLS    = 256,
    parameter int DEPTH_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Configuration write
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [8:0]  i_cfg_symbol_count,
    // Input channel
    input  wire         i_valid,
    output logic        o_stall,
    input  wire         i_func,
    input  wire  [7:0]  i_entry_index,
    input  wire  [31:0] i_entry_start,
    input  wire  [31:0] i_entry_size,
    input  wire         i_entry_is_func,
    input  wire  [31:0] i_cur_pc,
    input  wire  [31:0] i_target_pc,
    // Result channel
    output logic        o_valid,
    input  wire         i_stall,
    output logic [1:0]  o_event_res,
    output logic [7:0]  o_from_index,
    output logic [7:0]  o_to_index,
    output logic [31:0] o_from_start,
    output logic [31:0] o_to_start,
    output logic [15:0] o_indent,
    output logic        o_from_missed,
    output logic        o_to_missed
);

    localparam int IDX_W = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;

    logic [8:0]        r_count;
    logic              adv;
    logic              res_valid;

    logic              c_valid    [0:SYMBOLS];
    fcrt_pkg::t_token  c_tok      [0:SYMBOLS];
    fcrt_pkg::t_hit    c_from     [0:SYMBOLS];
    fcrt_pkg::t_hit    c_to       [0:SYMBOLS];
    logic [IDX_W-1:0]  c_from_idx [0:SYMBOLS];
    logic [IDX_W-1:0]  c_to_idx   [0:SYMBOLS];

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 9'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_count <= i_cfg_symbol_count;
        end
    end

    // Whole chain moves when the result register is free or being taken
    assign adv     = !res_valid || !i_stall;
    assign o_stall = !adv;
    assign o_valid = res_valid;

    // Chain head: pack the item, start both lookups empty
    always_comb begin
        c_valid[0]         = i_valid;
        c_tok[0].func      = i_func;
        c_tok[0].idx       = i_entry_index;
        c_tok[0].a         = i_func ? i_cur_pc : i_entry_start;
        c_tok[0].b         = i_func ? i_target_pc : i_entry_size;
        c_tok[0].is_func   = i_entry_is_func;
        c_from[0].found    = 1'b0;
        c_from[0].off      = '1;
        c_from[0].start    = 32'd0;
        c_to[0]            = c_from[0];
        c_from_idx[0]      = '0;
        c_to_idx[0]        = '0;
    end

    // Row of table cells
    for (genvar g = 0; g < SYMBOLS; g++) begin : g_cell
        fcrt_cell #(
            .CELL_IDX (g),
            .IDX_W    (IDX_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_adv      (adv),
            .i_count    (r_count),
            .i_valid    (c_valid[g]),
            .i_tok      (c_tok[g]),
            .i_from     (c_from[g]),
            .i_from_idx (c_from_idx[g]),
            .i_to       (c_to[g]),
            .i_to_idx   (c_to_idx[g]),
            .o_valid    (c_valid[g+1]),
            .o_tok      (c_tok[g+1]),
            .o_from     (c_from[g+1]),
            .o_from_idx (c_from_idx[g+1]),
            .o_to       (c_to[g+1]),
            .o_to_idx   (c_to_idx[g+1])
        );
    end

    // Classifier and result register
    fcrt_event #(
        .IDX_W      (IDX_W),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_event (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_count       (r_count),
        .i_valid       (c_valid[SYMBOLS]),
        .i_tok         (c_tok[SYMBOLS]),
        .i_from        (c_from[SYMBOLS]),
        .i_from_idx    (c_from_idx[SYMBOLS]),
        .i_to          (c_to[SYMBOLS]),
        .i_to_idx      (c_to_idx[SYMBOLS]),
        .o_valid       (res_valid),
        .o_event_res   (o_event_res),
        .o_from_index  (o_from_index),
        .o_to_index    (o_to_index),
        .o_from_start  (o_from_start),
        .o_to_start    (o_to_start),
        .o_indent      (o_indent),
        .o_from_missed (o_from_missed),
        .o_to_missed   (o_to_missed)
    );

endmodule
`default_nettype wire

FILE: rtl/core/fcrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// fcrt_cell - one symbol table slot of the lookup chain
// Holds one entry, writes it when a matching load passes, and folds it into
// both running lookups of a passing trace item.
// ============================================================================
module fcrt_cell #(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 8
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_adv,
    input  wire  [8:0]            i_count,
    input  wire                   i_valid,
    input  wire fcrt_pkg::t_token i_tok,
    input  wire fcrt_pkg::t_hit   i_from,
    input  wire  [IDX_W-1:0]      i_from_idx,
    input  wire fcrt_pkg::t_hit   i_to,
    input  wire  [IDX_W-1:0]      i_to_idx,
    output logic                  o_valid,
    output fcrt_pkg::t_token      o_tok,
    output fcrt_pkg::t_hit        o_from,
    output logic [IDX_W-1:0]      o_from_idx,
    output fcrt_pkg::t_hit        o_to,
    output logic [IDX_W-1:0]      o_to_idx
);

    localparam logic [31:0]      MY_IDX = 32'(CELL_IDX);
    localparam logic [IDX_W-1:0] MY_SEL = IDX_W'(CELL_IDX);

    // Stored entry (no reset: undefined until loaded)
    logic [31:0] r_start;
    logic [31:0] r_size;
    logic        r_is_func;

    logic               r_valid;
    fcrt_pkg::t_token   r_tok;
    fcrt_pkg::t_hit     r_from;
    fcrt_pkg::t_hit     r_to;
    logic [IDX_W-1:0]   r_from_idx;
    logic [IDX_W-1:0]   r_to_idx;

    logic               load_hit;
    logic               active;
    fcrt_pkg::t_hit     from_seed;
    fcrt_pkg::t_hit     to_seed;
    fcrt_pkg::t_match   m_from;
    fcrt_pkg::t_match   m_to;
    fcrt_pkg::t_hit     n_from;
    fcrt_pkg::t_hit     n_to;
    logic [IDX_W-1:0]   n_from_idx;
    logic [IDX_W-1:0]   n_to_idx;

    assign load_hit = i_valid && i_adv && !i_tok.func && ({24'b0, i_tok.idx} == MY_IDX);
    assign active   = i_tok.func && r_is_func && (MY_IDX < {23'b0, i_count});

    // Slot 0 seeds the fallback start of both lookups
    always_comb begin
        from_seed = i_from;
        to_seed   = i_to;
        if (CELL_IDX == 0) begin
            from_seed.start = r_start;
            to_seed.start   = r_start;
        end
    end

    // Lookup step for both addresses
    always_comb begin
        m_from     = fcrt_pkg::match_step(from_seed, i_tok.a, r_start, r_size, active);
        m_to       = fcrt_pkg::match_step(to_seed, i_tok.b, r_start, r_size, active);
        n_from     = m_from.hit;
        n_to       = m_to.hit;
        n_from_idx = m_from.take ? MY_SEL : i_from_idx;
        n_to_idx   = m_to.take ? MY_SEL : i_to_idx;
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (load_hit) begin
            r_start   <= i_tok.a;
            r_size    <= i_tok.b;
            r_is_func <= i_tok.is_func;
        end
    end

    // Token valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    // Token payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tok      <= i_tok;
            r_from     <= n_from;
            r_to       <= n_to;
            r_from_idx <= n_from_idx;
            r_to_idx   <= n_to_idx;
        end
    end

    assign o_valid    = r_valid;
    assign o_tok      = r_tok;
    assign o_from     = r_from;
    assign o_to       = r_to;
    assign o_from_idx = r_from_idx;
    assign o_to_idx   = r_to_idx;

endmodule
`default_nettype wire

FILE: rtl/core/fcrt_event.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// fcrt_event - call/return classifier and result register
// Classifies the item leaving the chain, tracks the call depth and holds
// the result until it is taken.
// ============================================================================
module fcrt_event #(
    parameter int IDX_W      = 8,
    parameter int DEPTH_BITS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_adv,
    input  wire  [8:0]           i_count,
    input  wire                  i_valid,
    input  wire fcrt_pkg::t_token i_tok,
    input  wire fcrt_pkg::t_hit  i_from,
    input  wire  [IDX_W-1:0]     i_from_idx,
    input  wire fcrt_pkg::t_hit  i_to,
    input  wire  [IDX_W-1:0]     i_to_idx,
    output logic                 o_valid,
    output logic [1:0]           o_event_res,
    output logic [7:0]           o_from_index,
    output logic [7:0]           o_to_index,
    output logic [31:0]          o_from_start,
    output logic [31:0]          o_to_start,
    output logic [15:0]          o_indent,
    output logic                 o_from_missed,
    output logic                 o_to_missed
);

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

    logic [DEPTH_BITS-1:0] r_depth;
    logic [DEPTH_BITS-1:0] n_depth;
    logic                  r_valid;
    fcrt_pkg::t_event      r_event;
    fcrt_pkg::t_event      n_event;
    logic [7:0]            r_from_index;
    logic [7:0]            r_to_index;
    logic [31:0]           r_from_start;
    logic [31:0]           r_to_start;
    logic [15:0]           r_indent;
    logic                  r_from_missed;
    logic                  r_to_missed;
    logic [7:0]            n_from_index;
    logic [7:0]            n_to_index;
    logic [31:0]           n_from_start;
    logic [31:0]           n_to_start;
    logic [15:0]           n_indent;
    logic                  n_from_missed;
    logic                  n_to_missed;

    logic                  quiet;
    logic                  take;
    logic [IDX_W+7:0]      from_idx_ext;
    logic [IDX_W+7:0]      to_idx_ext;
    logic [DEPTH_BITS+15:0] depth_ext;
    logic [DEPTH_BITS+15:0] dec_ext;
    logic [DEPTH_BITS-1:0] depth_dec;

    assign take         = i_adv && i_valid;
    assign from_idx_ext = {8'b0, i_from_idx};
    assign to_idx_ext   = {8'b0, i_to_idx};
    assign depth_dec    = r_depth - DEPTH_BITS'(1);
    assign depth_ext    = {16'b0, r_depth};
    assign dec_ext      = {16'b0, depth_dec};

    // No event for loads, sequential steps, an empty table or the same entry
    assign quiet = !i_tok.func || (i_tok.b == (i_tok.a + fcrt_pkg::STEP_BYTES)) ||
                   (i_count == 9'd0) || (i_from_idx == i_to_idx);

    // Result fields and next depth
    always_comb begin
        n_event       = fcrt_pkg::EV_NONE;
        n_from_index  = 8'd0;
        n_to_index    = 8'd0;
        n_from_start  = 32'd0;
        n_to_start    = 32'd0;
        n_indent      = 16'd0;
        n_from_missed = 1'b0;
        n_to_missed   = 1'b0;
        n_depth       = r_depth;
        if (!quiet) begin
            n_from_index  = from_idx_ext[7:0];
            n_to_index    = to_idx_ext[7:0];
            n_from_start  = i_from.start;
            n_to_start    = i_to.start;
            n_from_missed = !i_from.found;
            n_to_missed   = !i_to.found;
            if (i_to.start == i_tok.b) begin
                n_event  = fcrt_pkg::EV_CALL;
                n_indent = depth_ext[15:0];
                if (r_depth != DEPTH_MAX) begin
                    n_depth = r_depth + DEPTH_BITS'(1);
                end
            end else if (r_depth == '0) begin
                n_event = fcrt_pkg::EV_UNDER;
            end else begin
                n_event  = fcrt_pkg::EV_RET;
                n_indent = dec_ext[15:0];
                n_depth  = depth_dec;
            end
        end
    end

    // Call depth and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
            if (take) begin
                r_depth <= n_depth;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_event       <= n_event;
            r_from_index  <= n_from_index;
            r_to_index    <= n_to_index;
            r_from_start  <= n_from_start;
            r_to_start    <= n_to_start;
            r_indent      <= n_indent;
            r_from_missed <= n_from_missed;
            r_to_missed   <= n_to_missed;
        end
    end

    assign o_valid       = r_valid;
    assign o_event_res   = r_event;
    assign o_from_index  = r_from_index;
    assign o_to_index    = r_to_index;
    assign o_from_start  = r_from_start;
    assign o_to_start    = r_to_start;
    assign o_indent      = r_indent;
    assign o_from_missed = r_from_missed;
    assign o_to_missed   = r_to_missed;

endmodule
`default_nettype wire
